FILE: rtl/core/mmid_pkg.sv
package mmid_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_FIELD_W = 4;
  localparam int SYM_FIELD_W = 7;
  localparam int VALUE_W = 8;
  localparam int INDEX_W = 64;
  localparam int LEN_W = 5;
  localparam int BYTE_W = 8;

  localparam logic [ACTION_W-1:0] ACT_CHARSET = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SIZE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FIRST = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_TRANS = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DECODE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ORD,
    S_SYM,
    S_OUT
  } mmid_state_t;

endpackage

FILE: rtl/core/mmid_in_if.sv
interface mmid_in_if;
  logic                              valid;
  logic                              ready;
  logic [mmid_pkg::ACTION_W-1:0]     action;
  logic [mmid_pkg::POS_FIELD_W-1:0]  position;
  logic [mmid_pkg::SYM_FIELD_W-1:0]  prev_symbol;
  logic [mmid_pkg::SYM_FIELD_W-1:0]  rank;
  logic [mmid_pkg::VALUE_W-1:0]      value;
  logic [mmid_pkg::INDEX_W-1:0]      index;

  modport source (output valid, action, position, prev_symbol, rank, value, index,
                  input ready);
  modport sink (input valid, action, position, prev_symbol, rank, value, index,
                output ready);
endinterface

FILE: rtl/core/mmid_out_if.sv
interface mmid_out_if;
  logic                              valid;
  logic                              ready;
  logic [mmid_pkg::BYTE_W-1:0]       out_byte;
  logic [mmid_pkg::POS_FIELD_W-1:0]  out_position;
  logic                              last;

  modport source (output valid, out_byte, out_position, last, input ready);
  modport sink (input valid, out_byte, out_position, last, output ready);
endinterface

FILE: rtl/core/markov_mask_index_decoder.sv
// Markov mask index decoder: turns a 64-bit candidate index into a string of
// string_length bytes by mixed-radix decoding, one output byte per position
// in position order, the final one flagged with last. Table-load requests
// (charset byte, position size, first-position order, transition order) are
// taken only while idle and return nothing; tables hold garbage until
// loaded, so load every entry a decode will touch. A decode request runs one
// bit-serial restoring divider of the index by the position size for each
// position, then the order-table read and the charset read into the output
// register, then holds the byte until the sink takes it. in_chan.ready
// stays low from the decode request until the last byte is taken.
// cfg_ready is always high; write string_length only while idle.
module markov_mask_index_decoder #(
  parameter int POSITION_COUNT = 16,
  parameter int MAX_SYMBOLS = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mmid_in_if.sink                     in_chan,
  mmid_out_if.source                  out_chan,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mmid_pkg::LEN_W-1:0]  cfg_data
);
  import mmid_pkg::*;

  localparam int SYM_W = $clog2(MAX_SYMBOLS);
  localparam int POS_W = (POSITION_COUNT > 1) ? $clog2(POSITION_COUNT) : 1;
  localparam int TR_AW = POS_W + 2 * SYM_W;
  localparam int TR_DEPTH = 1 << TR_AW;
  localparam int CNT_W = $clog2(INDEX_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(INDEX_W - 1);
  localparam logic [8:0] SYM_LIM = 9'(MAX_SYMBOLS);
  localparam logic [6:0] POS_LIM = 7'(POSITION_COUNT);

  // Reduce a written symbol index modulo the symbol count, restoring style.
  function automatic logic [SYM_W-1:0] sym_mod(input logic [VALUE_W-1:0] v);
    logic [8:0] r;
    r = '0;
    for (int i = VALUE_W - 1; i >= 0; i--) begin
      r = {r[7:0], v[i]};
      if (r >= SYM_LIM) r = r - SYM_LIM;
    end
    return r[SYM_W-1:0];
  endfunction

  // Tables
  logic [BYTE_W-1:0] symbol_bytes [MAX_SYMBOLS];
  logic [7:0]        position_sizes [POSITION_COUNT];
  logic [SYM_W-1:0]  first_order [MAX_SYMBOLS];
  logic [SYM_W-1:0]  transition_order [TR_DEPTH];

  mmid_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [INDEX_W-1:0] idx_r;
  logic [7:0]        rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [POS_W-1:0]  p_r;
  logic [POS_W-1:0]  last_pos_r;
  logic [SYM_W-1:0]  cur_r;
  logic [SYM_W-1:0]  first_rd_r;
  logic [SYM_W-1:0]  trans_rd_r;
  logic [BYTE_W-1:0] byte_r;

  logic              in_fire;
  logic              out_fire;
  logic              is_last;
  logic [15:0]       rank_ext, prev_ext, pos_ext;
  logic [SYM_W-1:0]  rank_s, prev_s, wr_sym;
  logic [POS_W-1:0]  pos_s;
  logic              rank_ok, prev_ok, pos_ok;
  logic [8:0]        size;
  logic [8:0]        rem_shift;
  logic              q_bit;
  logic [7:0]        rem_step;
  logic [SYM_W-1:0]  cur_sel;
  logic [TR_AW-1:0]  tr_waddr, tr_raddr;
  logic [6:0]        eff_len;
  logic [7:0]        p_ext;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign cfg_ready = 1'b1;

  // Table-write address decode; drop writes that fall outside a table.
  assign rank_ext = {9'd0, in_chan.rank};
  assign prev_ext = {9'd0, in_chan.prev_symbol};
  assign pos_ext  = {12'd0, in_chan.position};
  assign rank_s   = rank_ext[SYM_W-1:0];
  assign prev_s   = prev_ext[SYM_W-1:0];
  assign pos_s    = pos_ext[POS_W-1:0];
  assign rank_ok  = {2'b00, in_chan.rank} < SYM_LIM;
  assign prev_ok  = {2'b00, in_chan.prev_symbol} < SYM_LIM;
  assign pos_ok   = {3'b000, in_chan.position} < POS_LIM;
  assign wr_sym   = sym_mod(in_chan.value);
  assign tr_waddr = {pos_s, prev_s, rank_s};

  // Effective radix of the current position: zero reads as one, clamp at the
  // symbol count.
  always_comb begin
    size = {1'b0, position_sizes[p_r]};
    if (size == 9'd0) size = 9'd1;
    else if (size > SYM_LIM) size = SYM_LIM;
  end

  // One restoring step: bring the next index bit into the remainder and
  // shift the quotient bit back into the index register.
  assign rem_shift = {rem_r, idx_r[INDEX_W-1]};
  assign q_bit     = rem_shift >= size;
  always_comb begin
    rem_step = rem_shift[7:0];
    if (q_bit) rem_step = 8'(rem_shift - size);
  end

  // Row of the transition table: this position, previous symbol, rank.
  assign tr_raddr = {p_r, cur_r, rem_r[SYM_W-1:0]};
  assign cur_sel  = (p_r == '0) ? first_rd_r : trans_rd_r;

  // Effective string length, clamped to 1..POSITION_COUNT.
  always_comb begin
    eff_len = {2'b00, len_r};
    if (eff_len == 7'd0) eff_len = 7'd1;
    else if (eff_len > POS_LIM) eff_len = POS_LIM;
  end

  assign is_last = (p_r == last_pos_r);
  assign p_ext   = 8'(p_r);

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = (state_r == S_OUT);
  assign out_chan.out_byte     = byte_r;
  assign out_chan.out_position = p_ext[3:0];
  assign out_chan.last         = is_last;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_chan.action == ACT_DECODE) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = S_ORD;
      end
      S_ORD: state_nxt = S_SYM;
      S_SYM: state_nxt = S_OUT;
      S_OUT: begin
        if (out_chan.ready) state_nxt = is_last ? S_IDLE : S_DIV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= LEN_W'(1);
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) len_r <= cfg_data;
    end
  end

  // Divider and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      p_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_chan.action == ACT_DECODE) begin
            idx_r      <= in_chan.index;
            rem_r      <= '0;
            cnt_r      <= '0;
            p_r        <= '0;
            last_pos_r <= POS_W'(eff_len - 7'd1);
          end
        end
        S_DIV: begin
          idx_r <= {idx_r[INDEX_W-2:0], q_bit};
          rem_r <= rem_step;
          cnt_r <= cnt_r + CNT_W'(1);
        end
        S_SYM: cur_r <= cur_sel;
        S_OUT: begin
          // Advance to the next position once the byte is taken.
          if (out_fire && !is_last) begin
            p_r   <= p_r + POS_W'(1);
            rem_r <= '0;
            cnt_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Table memories: loads while idle, registered reads during a decode.
  always_ff @(posedge clk) begin
    if (in_fire && in_chan.action == ACT_CHARSET && rank_ok)
      symbol_bytes[rank_s] <= in_chan.value;
    if (state_r == S_SYM)
      byte_r <= symbol_bytes[cur_sel];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.action == ACT_SIZE && pos_ok)
      position_sizes[pos_s] <= in_chan.value;
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.action == ACT_FIRST && rank_ok)
      first_order[rank_s] <= wr_sym;
    if (state_r == S_ORD)
      first_rd_r <= first_order[rem_r[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.action == ACT_TRANS && pos_ok && prev_ok && rank_ok)
      transition_order[tr_waddr] <= wr_sym;
    if (state_r == S_ORD)
      trans_rd_r <= transition_order[tr_raddr];
  end

  // Checks
  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !out_chan.valid)
    else $error("input ready while a byte is pending");

  a_decode_starts_divider: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.action == ACT_DECODE |=> state_r == S_DIV && cnt_r == '0)
    else $error("decode did not start the divider");

  a_rank_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ORD |-> {1'b0, rem_r} < size)
    else $error("remainder not below position size");

  a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> p_r <= last_pos_r)
    else $error("position beyond string length");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_chan.last |=> in_chan.ready)
    else $error("not ready after final byte");

endmodule
